// ----- src/rlgm_pkg.sv -----
//------------------------------------------------------------------------------
// rlgm_pkg
// Shared constants, register indexes and elaboration-time helpers for the
// RGBA levels and gamma mapper.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rlgm_pkg;

  localparam int CHANNEL_BITS_DEF    = 16;
  localparam int GAMMA_FRAC_BITS_DEF = 12;

  localparam int T_FRAC  = 24;
  localparam int T_W     = T_FRAC + 1;
  localparam int MQ      = 30;
  localparam int LG_FRAC = 16;
  localparam int NL_W    = 21;

  localparam int FIELD_W    = 16;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 3;

  localparam logic [CFG_ADDR_W-1:0] REG_COMPOSITE_LEVELS = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_RED_LEVELS       = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_GREEN_LEVELS     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_BLUE_LEVELS      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_ALPHA_LEVELS     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_MAIN_GAMMAS      = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_ALPHA_GAMMA      = 3'd6;

  localparam logic [63:0] LEVELS_RESET      = 64'hFFFF_0000_FFFF_0000;
  localparam logic [63:0] MAIN_GAMMAS_RESET = 64'h1000_1000_1000_1000;
  localparam logic [15:0] ALPHA_GAMMA_RESET = 16'h1000;

  function automatic int div2_num_w(input int gf);
    return NL_W + 1 + gf;
  endfunction

  // Cycles from a sample entering one levels map to its registered result.
  function automatic int map_lat(input int gf);
    return 64 + div2_num_w(gf);
  endfunction

  function automatic logic [63:0] sqrt_floor(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] xv;
    r  = '0;
    b  = 64'd1 << 62;
    xv = x;
    for (int i = 0; i < 32; i++) begin
      if (b > xv) begin
        b = b >> 2;
      end
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 0) begin
        if (xv >= r + b) begin
          xv = xv - (r + b);
          r  = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // Q.30 factor 2^(-2^-k), built from repeated square roots of one half.
  function automatic logic [MQ-1:0] exp_factor(input int k);
    logic [63:0] c;
    c = 64'd1 << (MQ - 1);
    for (int j = 1; j <= k; j++) begin
      c = sqrt_floor(c << MQ);
    end
    return c[MQ-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- src/rgba_levels_gamma_mapper_core.sv -----
//------------------------------------------------------------------------------
// rgba_levels_gamma_mapper_core
// RGBA levels adjustment with gamma: four per-channel map lanes, three
// composite map lanes for color, and a merging output stage with skid buffer.
//------------------------------------------------------------------------------
// Path: an input transaction passes the two chained map lanes and then the output
//   register before output valid; each map lane is dominated by its two
//   one-bit-per-stage dividers.
// Throughput: one pixel per clock; the pipeline stalls only when the output
//   register and the skid register both hold a pixel.
// Reset: configuration registers return to identity levels and unit gammas;
//   the valid chain and the output and skid valid flags are cleared.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgba_levels_gamma_mapper_core #(
  parameter int CHANNEL_BITS    = rlgm_pkg::CHANNEL_BITS_DEF,
  parameter int GAMMA_FRAC_BITS = rlgm_pkg::GAMMA_FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // red_in[15:0], green_in[31:16], blue_in[47:32], alpha_in[63:48]
  input  wire logic [63:0]                       in_tdata,
  input  wire logic                              in_tlast,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // red_out[15:0], green_out[31:16], blue_out[47:32], alpha_out[63:48]
  output logic      [63:0]                       out_tdata,
  output logic                                   out_tlast,
  // gamma_error[0]
  output logic                                   out_tuser,
  input  wire logic                              cfg_we,
  input  wire logic [rlgm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [rlgm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int CB  = CHANNEL_BITS;
  localparam int ML  = rlgm_pkg::map_lat(GAMMA_FRAC_BITS);
  localparam int TOT = 2 * ML;

  logic [63:0] comp_lv_r, red_lv_r, green_lv_r, blue_lv_r, alpha_lv_r, gammas_r;
  logic [15:0] alpha_g_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comp_lv_r  <= rlgm_pkg::LEVELS_RESET;
      red_lv_r   <= rlgm_pkg::LEVELS_RESET;
      green_lv_r <= rlgm_pkg::LEVELS_RESET;
      blue_lv_r  <= rlgm_pkg::LEVELS_RESET;
      alpha_lv_r <= rlgm_pkg::LEVELS_RESET;
      gammas_r   <= rlgm_pkg::MAIN_GAMMAS_RESET;
      alpha_g_r  <= rlgm_pkg::ALPHA_GAMMA_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        rlgm_pkg::REG_COMPOSITE_LEVELS: comp_lv_r  <= cfg_wdata;
        rlgm_pkg::REG_RED_LEVELS:       red_lv_r   <= cfg_wdata;
        rlgm_pkg::REG_GREEN_LEVELS:     green_lv_r <= cfg_wdata;
        rlgm_pkg::REG_BLUE_LEVELS:      blue_lv_r  <= cfg_wdata;
        rlgm_pkg::REG_ALPHA_LEVELS:     alpha_lv_r <= cfg_wdata;
        rlgm_pkg::REG_MAIN_GAMMAS:      gammas_r   <= cfg_wdata;
        rlgm_pkg::REG_ALPHA_GAMMA:      alpha_g_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic skid_vld_r;
  assign en        = !skid_vld_r;
  assign in_tready = en && rst_n;

  // First pass: one lane per channel.
  logic [CB-1:0] r1, g1, b1, a1, r2, g2, b2;

  rlgm_map #(.CHANNEL_BITS(CB), .GAMMA_FRAC_BITS(GAMMA_FRAC_BITS)) u_map_red (
    .clk(clk), .en(en), .val_i(in_tdata[0 +: CB]), .levels_i(red_lv_r),
    .gamma_i(gammas_r[31:16]), .res_o(r1)
  );
  rlgm_map #(.CHANNEL_BITS(CB), .GAMMA_FRAC_BITS(GAMMA_FRAC_BITS)) u_map_green (
    .clk(clk), .en(en), .val_i(in_tdata[16 +: CB]), .levels_i(green_lv_r),
    .gamma_i(gammas_r[47:32]), .res_o(g1)
  );
  rlgm_map #(.CHANNEL_BITS(CB), .GAMMA_FRAC_BITS(GAMMA_FRAC_BITS)) u_map_blue (
    .clk(clk), .en(en), .val_i(in_tdata[32 +: CB]), .levels_i(blue_lv_r),
    .gamma_i(gammas_r[63:48]), .res_o(b1)
  );
  rlgm_map #(.CHANNEL_BITS(CB), .GAMMA_FRAC_BITS(GAMMA_FRAC_BITS)) u_map_alpha (
    .clk(clk), .en(en), .val_i(in_tdata[48 +: CB]), .levels_i(alpha_lv_r),
    .gamma_i(alpha_g_r), .res_o(a1)
  );

  // Second pass: composite map on the color lanes.
  rlgm_map #(.CHANNEL_BITS(CB), .GAMMA_FRAC_BITS(GAMMA_FRAC_BITS)) u_comp_red (
    .clk(clk), .en(en), .val_i(r1), .levels_i(comp_lv_r),
    .gamma_i(gammas_r[15:0]), .res_o(r2)
  );
  rlgm_map #(.CHANNEL_BITS(CB), .GAMMA_FRAC_BITS(GAMMA_FRAC_BITS)) u_comp_green (
    .clk(clk), .en(en), .val_i(g1), .levels_i(comp_lv_r),
    .gamma_i(gammas_r[15:0]), .res_o(g2)
  );
  rlgm_map #(.CHANNEL_BITS(CB), .GAMMA_FRAC_BITS(GAMMA_FRAC_BITS)) u_comp_blue (
    .clk(clk), .en(en), .val_i(b1), .levels_i(comp_lv_r),
    .gamma_i(gammas_r[15:0]), .res_o(b2)
  );

  logic          vld_r   [TOT];
  logic          last_r  [TOT];
  logic [CB-1:0] adly_r  [ML];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TOT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_tvalid;
      for (int i = 1; i < TOT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      last_r[0] <= in_tlast;
      for (int i = 1; i < TOT; i++) begin
        last_r[i] <= last_r[i-1];
      end
      adly_r[0] <= a1;
      for (int i = 1; i < ML; i++) begin
        adly_r[i] <= adly_r[i-1];
      end
    end
  end

  // Merge the lanes; a zero gamma anywhere forces all channels to zero.
  logic        gamma_err;
  logic [63:0] mrg_data;

  assign gamma_err = (gammas_r[15:0] == '0) || (gammas_r[31:16] == '0) ||
                     (gammas_r[47:32] == '0) || (gammas_r[63:48] == '0) ||
                     (alpha_g_r == '0);
  assign mrg_data  = gamma_err ? '0 :
                     {16'(adly_r[ML-1]), 16'(b2), 16'(g2), 16'(r2)};

  logic        out_vld_r;
  logic [63:0] out_data_r, skid_data_r;
  logic        out_last_r, skid_last_r, out_err_r, skid_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!out_vld_r || out_tready) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= vld_r[TOT-1];
      end
    end else if (vld_r[TOT-1] && en) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || out_tready) begin
      if (skid_vld_r) begin
        out_data_r <= skid_data_r;
        out_last_r <= skid_last_r;
        out_err_r  <= skid_err_r;
      end else begin
        out_data_r <= mrg_data;
        out_last_r <= last_r[TOT-1];
        out_err_r  <= gamma_err;
      end
    end else if (en) begin
      skid_data_r <= mrg_data;
      skid_last_r <= last_r[TOT-1];
      skid_err_r  <= gamma_err;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid register holds a pixel while the output register is empty");

  a_skid_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> !in_tready)
    else $error("input accepted while the skid register is full");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_vld_r) |-> $past(out_vld_r && !out_tready))
    else $error("skid register filled while the output was free");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_err_r) |-> (out_data_r == '0))
    else $error("gamma error transaction carries nonzero channels");

endmodule

`default_nettype wire

// ----- src/rlgm_div.sv -----
//------------------------------------------------------------------------------
// rlgm_div
// Pipelined restoring divider, one quotient bit per stage, with a sideband
// bus that travels alongside the operands.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rlgm_div #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 16,
  parameter int Q_W   = 25,
  parameter int SB_W  = 2
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  input  wire logic [SB_W-1:0]  sb_i,
  output logic      [Q_W-1:0]   quo_o,
  output logic      [SB_W-1:0]  sb_o
);

  logic [DEN_W-1:0] rem_r [Q_W];
  logic [DEN_W-1:0] den_r [Q_W];
  logic [NUM_W-1:0] num_r [Q_W];
  logic [Q_W-1:0]   quo_r [Q_W];
  logic [SB_W-1:0]  sb_r  [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic [DEN_W-1:0] cur_rem;
    logic [DEN_W-1:0] cur_den;
    logic [NUM_W-1:0] cur_num;
    logic [Q_W-1:0]   cur_quo;
    logic [SB_W-1:0]  cur_sb;
    logic [DEN_W:0]   trial;
    logic             ge;
    logic [DEN_W:0]   diff;

    if (k == 0) begin : g_first
      assign cur_rem = DEN_W'(num_i >> Q_W);
      assign cur_den = den_i;
      assign cur_num = num_i;
      assign cur_quo = '0;
      assign cur_sb  = sb_i;
    end else begin : g_next
      assign cur_rem = rem_r[k-1];
      assign cur_den = den_r[k-1];
      assign cur_num = num_r[k-1];
      assign cur_quo = quo_r[k-1];
      assign cur_sb  = sb_r[k-1];
    end

    assign trial = {cur_rem, cur_num[Q_W-1-k]};
    assign ge    = trial >= {1'b0, cur_den};
    assign diff  = trial - {1'b0, cur_den};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        den_r[k] <= cur_den;
        num_r[k] <= cur_num;
        quo_r[k] <= {cur_quo[Q_W-2:0], ge};
        sb_r[k]  <= cur_sb;
      end
    end
  end

  assign quo_o = quo_r[Q_W-1];
  assign sb_o  = sb_r[Q_W-1];

endmodule

`default_nettype wire

// ----- src/rlgm_map.sv -----
//------------------------------------------------------------------------------
// rlgm_map
// One levels map lane: stretch, clamp, gamma power by log2/exp2, and output
// range mapping, fully pipelined at one sample per enabled cycle.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rlgm_map #(
  parameter int CHANNEL_BITS    = rlgm_pkg::CHANNEL_BITS_DEF,
  parameter int GAMMA_FRAC_BITS = rlgm_pkg::GAMMA_FRAC_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [CHANNEL_BITS-1:0] val_i,
  input  wire logic [63:0]             levels_i,
  input  wire logic [15:0]             gamma_i,
  output logic      [CHANNEL_BITS-1:0] res_o
);

  localparam int CB      = CHANNEL_BITS;
  localparam int TF      = rlgm_pkg::T_FRAC;
  localparam int TW      = rlgm_pkg::T_W;
  localparam int MQ      = rlgm_pkg::MQ;
  localparam int LG      = rlgm_pkg::LG_FRAC;
  localparam int NL_W    = rlgm_pkg::NL_W;
  localparam int NW1     = CB + TF;
  localparam int NW2     = rlgm_pkg::div2_num_w(GAMMA_FRAC_BITS);
  localparam int PRD_W   = TW + CB;
  localparam logic [CB-1:0] CHAN_MAX   = {CB{1'b1}};
  localparam logic [15:0]   GAMMA_ONE  = 16'(1 << GAMMA_FRAC_BITS);
  localparam logic [TW-1:0] T_ONE      = TW'(1) << TF;

  logic [CB-1:0] lo, hi, ol, oh;
  assign lo = levels_i[0  +: CB];
  assign hi = levels_i[16 +: CB];
  assign ol = levels_i[32 +: CB];
  assign oh = levels_i[48 +: CB];

  // Stretch setup.
  logic [CB-1:0] a_d_nxt, a_den_nxt, a_d_r, a_den_r;
  logic          a_zero_nxt, a_one_nxt, a_zero_r, a_one_r;

  always_comb begin
    if (hi == lo) begin
      a_zero_nxt = val_i <= lo;
      a_one_nxt  = 1'b0;
      a_d_nxt    = val_i - lo;
      a_den_nxt  = CHAN_MAX;
    end else if (hi > lo) begin
      a_zero_nxt = val_i <= lo;
      a_one_nxt  = val_i >= hi;
      a_d_nxt    = val_i - lo;
      a_den_nxt  = hi - lo;
    end else begin
      a_zero_nxt = val_i >= lo;
      a_one_nxt  = val_i <= hi;
      a_d_nxt    = lo - val_i;
      a_den_nxt  = lo - hi;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_d_r    <= a_d_nxt;
      a_den_r  <= a_den_nxt;
      a_zero_r <= a_zero_nxt;
      a_one_r  <= a_one_nxt;
    end
  end

  logic [NW1-1:0] div1_num;
  logic [TW-1:0]  div1_quo;
  logic [1:0]     div1_sb;

  assign div1_num = {a_d_r, TF'(0)} + NW1'(a_den_r >> 1);

  rlgm_div #(.NUM_W(NW1), .DEN_W(CB), .Q_W(TW), .SB_W(2)) u_div_stretch (
    .clk   (clk),
    .en    (en),
    .num_i (div1_num),
    .den_i (a_den_r),
    .sb_i  ({a_zero_r, a_one_r}),
    .quo_o (div1_quo),
    .sb_o  (div1_sb)
  );

  // Clamp and power bypass decision.
  logic [TW-1:0] b_t_nxt, b_t_r;
  logic          b_byp_r;

  always_comb begin
    if (div1_sb[1]) begin
      b_t_nxt = '0;
    end else if (div1_sb[0]) begin
      b_t_nxt = T_ONE;
    end else begin
      b_t_nxt = div1_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_t_r   <= b_t_nxt;
      b_byp_r <= (gamma_i == GAMMA_ONE) || (b_t_nxt == '0) || b_t_nxt[TF];
    end
  end

  // Normalize to a Q.30 mantissa.
  logic [4:0]  c_p_nxt, c_p_r;
  logic [MQ:0] c_m_r;
  logic [TW-1:0] c_t_r;
  logic        c_byp_r;

  always_comb begin
    c_p_nxt = '0;
    for (int i = 0; i < TF; i++) begin
      if (b_t_r[i]) begin
        c_p_nxt = 5'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_p_r   <= c_p_nxt;
      c_m_r   <= (MQ+1)'(b_t_r[TF-1:0]) << (5'(MQ) - c_p_nxt);
      c_t_r   <= b_t_r;
      c_byp_r <= b_byp_r;
    end
  end

  // log2 fraction by repeated squaring.
  logic [MQ:0]   sq_m_r   [LG];
  logic [LG-1:0] sq_f_r   [LG];
  logic [4:0]    sq_p_r   [LG];
  logic [TW-1:0] sq_t_r   [LG];
  logic          sq_byp_r [LG];

  for (genvar k = 0; k < LG; k++) begin : g_sq
    logic [MQ:0]       cur_m;
    logic [LG-1:0]     cur_f;
    logic [4:0]        cur_p;
    logic [TW-1:0]     cur_t;
    logic              cur_byp;
    logic [2*MQ+1:0]   prod;
    logic [MQ+1:0]     s;

    if (k == 0) begin : g_first
      assign cur_m   = c_m_r;
      assign cur_f   = '0;
      assign cur_p   = c_p_r;
      assign cur_t   = c_t_r;
      assign cur_byp = c_byp_r;
    end else begin : g_next
      assign cur_m   = sq_m_r[k-1];
      assign cur_f   = sq_f_r[k-1];
      assign cur_p   = sq_p_r[k-1];
      assign cur_t   = sq_t_r[k-1];
      assign cur_byp = sq_byp_r[k-1];
    end

    assign prod = (2*MQ+2)'(cur_m) * (2*MQ+2)'(cur_m);
    assign s    = prod[2*MQ+1:MQ];

    always_ff @(posedge clk) begin
      if (en) begin
        sq_m_r[k]   <= s[MQ+1] ? s[MQ+1:1] : s[MQ:0];
        sq_f_r[k]   <= cur_f | (LG'(s[MQ+1]) << (LG-1-k));
        sq_p_r[k]   <= cur_p;
        sq_t_r[k]   <= cur_t;
        sq_byp_r[k] <= cur_byp;
      end
    end
  end

  // Exponent divided by gamma.
  logic [NL_W-1:0] nl;
  logic [NW2-1:0]  div2_num;
  logic [NW2-1:0]  div2_quo;
  logic [TW:0]     div2_sb;

  assign nl       = (NL_W'(5'(TF) - sq_p_r[LG-1]) << LG) - NL_W'(sq_f_r[LG-1]);
  assign div2_num = (NW2'(nl) << GAMMA_FRAC_BITS) + NW2'(gamma_i >> 1);

  rlgm_div #(.NUM_W(NW2), .DEN_W(16), .Q_W(NW2), .SB_W(TW+1)) u_div_gamma (
    .clk   (clk),
    .en    (en),
    .num_i (div2_num),
    .den_i (gamma_i),
    .sb_i  ({sq_byp_r[LG-1], sq_t_r[LG-1]}),
    .quo_o (div2_quo),
    .sb_o  (div2_sb)
  );

  logic [4:0]    e_n_r;
  logic [LG-1:0] e_f_r;
  logic          e_ovf_r;
  logic [TW-1:0] e_t_r;
  logic          e_byp_r;

  always_ff @(posedge clk) begin
    if (en) begin
      e_n_r   <= div2_quo[LG +: 5];
      e_f_r   <= div2_quo[LG-1:0];
      e_ovf_r <= (div2_quo >> LG) > NW2'(TF);
      e_t_r   <= div2_sb[TW-1:0];
      e_byp_r <= div2_sb[TW];
    end
  end

  // exp2 of the fraction as a product of constant factors.
  logic [MQ:0]   ex_r_r   [LG];
  logic [4:0]    ex_n_r   [LG];
  logic [LG-1:0] ex_f_r   [LG];
  logic          ex_ovf_r [LG];
  logic [TW-1:0] ex_t_r   [LG];
  logic          ex_byp_r [LG];

  for (genvar k = 0; k < LG; k++) begin : g_ex
    localparam logic [MQ-1:0] FACTOR = rlgm_pkg::exp_factor(k + 1);
    logic [MQ:0]       cur_r;
    logic [4:0]        cur_n;
    logic [LG-1:0]     cur_f;
    logic              cur_ovf;
    logic [TW-1:0]     cur_t;
    logic              cur_byp;
    logic [2*MQ:0]     prod;
    logic [2*MQ:0]     rnd;

    if (k == 0) begin : g_first
      assign cur_r   = (MQ+1)'(1) << MQ;
      assign cur_n   = e_n_r;
      assign cur_f   = e_f_r;
      assign cur_ovf = e_ovf_r;
      assign cur_t   = e_t_r;
      assign cur_byp = e_byp_r;
    end else begin : g_next
      assign cur_r   = ex_r_r[k-1];
      assign cur_n   = ex_n_r[k-1];
      assign cur_f   = ex_f_r[k-1];
      assign cur_ovf = ex_ovf_r[k-1];
      assign cur_t   = ex_t_r[k-1];
      assign cur_byp = ex_byp_r[k-1];
    end

    assign prod = (2*MQ+1)'(cur_r) * (2*MQ+1)'(FACTOR);
    assign rnd  = (prod + ((2*MQ+1)'(1) << (MQ - 1))) >> MQ;

    always_ff @(posedge clk) begin
      if (en) begin
        ex_r_r[k]   <= cur_f[LG-1-k] ? rnd[MQ:0] : cur_r;
        ex_n_r[k]   <= cur_n;
        ex_f_r[k]   <= cur_f;
        ex_ovf_r[k] <= cur_ovf;
        ex_t_r[k]   <= cur_t;
        ex_byp_r[k] <= cur_byp;
      end
    end
  end

  // Integer part of the exponent as a rounded right shift.
  logic [5:0]    f_sh;
  logic [MQ+1:0] f_sum;
  logic [TW-1:0] f_t_nxt, f_t_r;

  assign f_sh  = 6'(MQ - TF) + 6'(ex_n_r[LG-1]);
  assign f_sum = (MQ+2)'(ex_r_r[LG-1]) + ((MQ+2)'(1) << (f_sh - 6'd1));

  always_comb begin
    if (ex_byp_r[LG-1]) begin
      f_t_nxt = ex_t_r[LG-1];
    end else if (ex_ovf_r[LG-1]) begin
      f_t_nxt = '0;
    end else begin
      f_t_nxt = TW'(f_sum >> f_sh);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_t_r <= f_t_nxt;
    end
  end

  // Output range mapping.
  logic             g_up;
  logic [CB-1:0]    g_span;
  logic [PRD_W-1:0] g_prod_r;
  logic             g_up_r;
  logic [PRD_W-1:0] h_rnd;
  logic [CB-1:0]    h_x;

  assign g_up   = oh >= ol;
  assign g_span = g_up ? (oh - ol) : (ol - oh);

  always_ff @(posedge clk) begin
    if (en) begin
      g_prod_r <= PRD_W'(f_t_r) * PRD_W'(g_span);
      g_up_r   <= g_up;
    end
  end

  assign h_rnd = g_prod_r + (PRD_W'(1) << (TF - 1));
  assign h_x   = CB'(h_rnd >> TF);

  always_ff @(posedge clk) begin
    if (en) begin
      res_o <= g_up_r ? (ol + h_x) : (ol - h_x);
    end
  end

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
//------------------------------------------------------------------------------
// testbench
// Self-checking bench for rgba_levels_gamma_mapper_core. Pixels stream in
// under several register settings. A scoreboard computes every result from its
// own copy of the levels and gamma registers and checks each output
// transaction in order.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct packed {
  logic        last;
  logic [15:0] alpha;
  logic [15:0] blue;
  logic [15:0] green;
  logic [15:0] red;
} pixel_t;

typedef struct packed {
  logic        err;
  logic        last;
  logic [15:0] alpha;
  logic [15:0] blue;
  logic [15:0] green;
  logic [15:0] red;
} mapped_t;

class levels_scoreboard;
  logic [63:0] regs [0:6];
  logic [63:0] exp_fac [1:16];
  mapped_t     pending_px [$];
  int          mismatches;
  int          checked;

  function new();
    logic [63:0] c;
    c = 64'd1 << 29;
    for (int i = 1; i <= 16; i++) begin
      c = isqrt(c << 30);
      exp_fac[i] = c;
    end
    regs[rlgm_pkg::REG_COMPOSITE_LEVELS] = rlgm_pkg::LEVELS_RESET;
    regs[rlgm_pkg::REG_RED_LEVELS]       = rlgm_pkg::LEVELS_RESET;
    regs[rlgm_pkg::REG_GREEN_LEVELS]     = rlgm_pkg::LEVELS_RESET;
    regs[rlgm_pkg::REG_BLUE_LEVELS]      = rlgm_pkg::LEVELS_RESET;
    regs[rlgm_pkg::REG_ALPHA_LEVELS]     = rlgm_pkg::LEVELS_RESET;
    regs[rlgm_pkg::REG_MAIN_GAMMAS]      = rlgm_pkg::MAIN_GAMMAS_RESET;
    regs[rlgm_pkg::REG_ALPHA_GAMMA]      = {48'd0, rlgm_pkg::ALPHA_GAMMA_RESET};
    mismatches = 0;
    checked = 0;
  endfunction

  function logic [63:0] isqrt(input logic [63:0] x);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] bitv;
    rem = x;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function void set_reg(input logic [2:0] idx, input logic [63:0] val);
    regs[idx] = (idx == rlgm_pkg::REG_ALPHA_GAMMA) ? (val & 64'hFFFF) : val;
  endfunction

  function logic [63:0] unit_value(input logic [63:0] v, input logic [63:0] lo,
                                   input logic [63:0] hi);
    if (hi == lo) begin
      if (v <= lo) return 0;
      return (((v - lo) << 24) + 64'd32767) / 64'd65535;
    end
    if (hi > lo) begin
      if (v <= lo) return 0;
      if (v >= hi) return 64'd1 << 24;
      return (((v - lo) << 24) + (hi - lo) / 2) / (hi - lo);
    end
    if (v >= lo) return 0;
    if (v <= hi) return 64'd1 << 24;
    return (((lo - v) << 24) + (lo - hi) / 2) / (lo - hi);
  endfunction

  function logic [63:0] apply_gamma(input logic [63:0] t, input logic [63:0] g);
    int          msb;
    int          n;
    int          sh;
    logic [63:0] m;
    logic [63:0] frac;
    logic [63:0] nl;
    logic [63:0] e;
    logic [63:0] f;
    logic [63:0] r;
    if (g == 64'd4096 || t == 0 || t >= (64'd1 << 24)) return t;
    if (g == 0) return 0;
    msb = 0;
    for (int i = 0; i < 24; i++) if (t[i]) msb = i;
    m = t << (30 - msb);
    frac = 0;
    for (int i = 1; i <= 16; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac = frac | (64'd1 << (16 - i));
      end
    end
    nl = (64'(24 - msb) << 16) - frac;
    e = ((nl << 12) + g / 2) / g;
    if ((e >> 16) > 24) return 0;
    n = int'(e >> 16);
    f = e & 64'hFFFF;
    r = 64'd1 << 30;
    for (int i = 1; i <= 16; i++) begin
      if (f[16 - i]) r = (r * exp_fac[i] + (64'd1 << 29)) >> 30;
    end
    sh = 6 + n;
    return (r + (64'd1 << (sh - 1))) >> sh;
  endfunction

  function logic [15:0] map_channel(input logic [15:0] v, input logic [63:0] lv,
                                    input logic [15:0] g);
    logic [63:0] t;
    logic [63:0] res;
    logic [63:0] ol;
    logic [63:0] oh;
    ol = lv[47:32];
    oh = lv[63:48];
    t = apply_gamma(unit_value(v, lv[15:0], lv[31:16]), g);
    if (oh >= ol) res = ol + ((t * (oh - ol) + (64'd1 << 23)) >> 24);
    else          res = ol - ((t * (ol - oh) + (64'd1 << 23)) >> 24);
    if (res > 64'hFFFF) res = 64'hFFFF;
    return res[15:0];
  endfunction

  function void note_pixel(input pixel_t px);
    mapped_t     m;
    logic [63:0] gm;
    logic [15:0] ga;
    logic [63:0] comp;
    gm = regs[rlgm_pkg::REG_MAIN_GAMMAS];
    ga = regs[rlgm_pkg::REG_ALPHA_GAMMA][15:0];
    comp = regs[rlgm_pkg::REG_COMPOSITE_LEVELS];
    m = '0;
    m.last = px.last;
    m.err = (gm[15:0] == 0 || gm[31:16] == 0 || gm[47:32] == 0 ||
             gm[63:48] == 0 || ga == 0);
    if (!m.err) begin
      m.red = map_channel(map_channel(px.red, regs[rlgm_pkg::REG_RED_LEVELS],
                                      gm[31:16]), comp, gm[15:0]);
      m.green = map_channel(map_channel(px.green, regs[rlgm_pkg::REG_GREEN_LEVELS],
                                        gm[47:32]), comp, gm[15:0]);
      m.blue = map_channel(map_channel(px.blue, regs[rlgm_pkg::REG_BLUE_LEVELS],
                                       gm[63:48]), comp, gm[15:0]);
      m.alpha = map_channel(px.alpha, regs[rlgm_pkg::REG_ALPHA_LEVELS], ga);
    end
    pending_px.push_back(m);
  endfunction

  function void check_result(input mapped_t got);
    mapped_t want;
    checked++;
    if (pending_px.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Unexpected output transaction %h", got);
      return;
    end
    want = pending_px.pop_front();
    if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
        got.alpha !== want.alpha || got.last !== want.last || got.err !== want.err) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"Mismatch: expected r=%h g=%h b=%h a=%h last=%b err=%b, ",
                  "got r=%h g=%h b=%h a=%h last=%b err=%b"},
                 want.red, want.green, want.blue, want.alpha, want.last, want.err,
                 got.red, got.green, got.blue, got.alpha, got.last, got.err);
    end
  endfunction
endclass

module testbench;
  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [63:0] cfg_wdata;

  levels_scoreboard sb;
  int send_idle;
  int recv_idle;
  int settings_used;
  int pixels_sent;

  rgba_levels_gamma_mapper_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Timed out.");
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result({out_tuser, out_tlast, out_tdata});
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic send_pixel(input pixel_t px);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {px.alpha, px.blue, px.green, px.red};
    in_tlast  <= px.last;
    do @(posedge clk); while (!in_tready);
    sb.note_pixel(px);
    pixels_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending_px.size() != 0) @(posedge clk);
    repeat (220) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  function automatic logic [15:0] pick_gamma();
    case ($urandom_range(9))
      0: return 16'h1000;
      1: return 16'h0001;
      2: return 16'hFFFF;
      3: return ($urandom_range(19) == 0) ? 16'h0000 : 16'h1000;
      default: return 16'($urandom_range(65535, 1));
    endcase
  endfunction

  function automatic logic [63:0] pick_levels();
    logic [15:0] lo;
    logic [15:0] hi;
    lo = 16'($urandom);
    hi = 16'($urandom);
    case ($urandom_range(5))
      0: begin lo = 16'h0000; hi = 16'hFFFF; end
      1: hi = lo;
      2: if (lo > hi) {lo, hi} = {hi, lo};
      default: ;
    endcase
    return {16'($urandom), 16'($urandom), hi, lo};
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    px = 65'({$urandom, $urandom, $urandom});
    if ($urandom_range(9) == 0) px.red = 16'hFFFF;
    if ($urandom_range(9) == 0) px.green = 16'h0000;
    return px;
  endfunction

  initial begin
    pixel_t px;
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    send_idle = 0;
    recv_idle = 0;
    settings_used = 1;
    pixels_sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: identity maps.
    send_pixel('{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
    send_pixel('{1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_pixel('{1'b0, 16'h8000, 16'h0001, 16'hFFFE, 16'h5555});
    send_pixel('{1'b1, 16'h0001, 16'h7FFF, 16'hAAAA, 16'h1234});
    drain();

    // Extreme gammas, inverted input and output ranges, equal input bounds.
    write_reg(rlgm_pkg::REG_COMPOSITE_LEVELS, 64'h0000_FFFF_0000_FFFF);
    write_reg(rlgm_pkg::REG_RED_LEVELS, 64'hFFFF_0000_1000_F000);
    write_reg(rlgm_pkg::REG_GREEN_LEVELS, 64'h8000_4000_4000_4000);
    write_reg(rlgm_pkg::REG_BLUE_LEVELS, 64'h0100_FF00_0000_0000);
    write_reg(rlgm_pkg::REG_ALPHA_LEVELS, 64'h0000_FFFF_FFFF_0000);
    write_reg(rlgm_pkg::REG_MAIN_GAMMAS, 64'hFFFF_0001_2000_0800);
    write_reg(rlgm_pkg::REG_ALPHA_GAMMA, 64'h0000_0000_0000_FFFF);
    cfg_we <= 1'b0;
    settings_used++;
    send_pixel('{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
    send_pixel('{1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_pixel('{1'b0, 16'h0001, 16'h4000, 16'h4001, 16'h1000});
    send_pixel('{1'b0, 16'h7FFF, 16'h3FFF, 16'h8000, 16'hF000});
    send_pixel('{1'b1, 16'h0002, 16'h4001, 16'h0800, 16'h0FFF});
    drain();

    // A zero gamma forces the error flag and zero channels.
    write_reg(rlgm_pkg::REG_MAIN_GAMMAS, 64'h1000_1000_0000_1000);
    cfg_we <= 1'b0;
    settings_used++;
    send_pixel('{1'b1, 16'hFFFF, 16'h1234, 16'h5678, 16'h9ABC});
    send_pixel('{1'b0, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF});
    drain();
    write_reg(rlgm_pkg::REG_MAIN_GAMMAS, rlgm_pkg::MAIN_GAMMAS_RESET);
    write_reg(rlgm_pkg::REG_ALPHA_GAMMA, 64'h0);
    cfg_we <= 1'b0;
    settings_used++;
    send_pixel('{1'b0, 16'h4321, 16'h1111, 16'h2222, 16'h3333});
    send_pixel('{1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph / 3)
        0: begin send_idle = 11; recv_idle = 83; end
        1: begin send_idle = 83; recv_idle = 11; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      write_reg(rlgm_pkg::REG_COMPOSITE_LEVELS, pick_levels());
      write_reg(rlgm_pkg::REG_RED_LEVELS, pick_levels());
      write_reg(rlgm_pkg::REG_GREEN_LEVELS, pick_levels());
      write_reg(rlgm_pkg::REG_BLUE_LEVELS, pick_levels());
      write_reg(rlgm_pkg::REG_ALPHA_LEVELS, pick_levels());
      write_reg(rlgm_pkg::REG_MAIN_GAMMAS,
                {pick_gamma(), pick_gamma(), pick_gamma(), pick_gamma()});
      write_reg(rlgm_pkg::REG_ALPHA_GAMMA, {48'($urandom), pick_gamma()});
      cfg_we <= 1'b0;
      settings_used++;
      for (int k = 0; k < 48; k++) begin
        px = random_pixel();
        send_pixel(px);
      end
      drain();
    end

    $display("Sent %0d pixels under %0d register settings; %0d results checked.",
             pixels_sent, settings_used, sb.checked);
    if (sb.pending_px.size() != 0) sb.mismatches++;
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches.", sb.mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ----- rgba_levels_gamma_mapper_core.f -----
src/rlgm_pkg.sv
src/rlgm_div.sv
src/rlgm_map.sv
src/rgba_levels_gamma_mapper_core.sv
sim/testbench.sv
